/* sv/assert_macros.svh */
// Assertion macros shared by the row expander RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/grx_pkg.sv */
// Shared types and constants for the indexed row expander.
// Used by grx_front, grx_queue, grx_back and the top level.
`timescale 1ns / 1ps

package grx_pkg;

	// Screen and palette limits
	localparam logic [10:0] MAX_WIDTH     = 11'd1024;
	localparam logic [10:0] MAX_HEIGHT    = 11'd1024;
	localparam int          PALETTE_DEPTH = 256;
	localparam logic [8:0]  PAL_COUNT_MAX = 9'd256;
	localparam logic [8:0]  GRAY_LIMIT    = 9'd255;
	localparam logic [7:0]  ALPHA_OPAQUE  = 8'hff;
	localparam logic [7:0]  ALPHA_CLEAR   = 8'h00;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// Input item kinds
	localparam logic [2:0] KIND_PAL_ENTRY = 3'd0;
	localparam logic [2:0] KIND_PAL_SIZE  = 3'd1;
	localparam logic [2:0] KIND_TRANSP    = 3'd2;
	localparam logic [2:0] KIND_DESC      = 3'd3;
	localparam logic [2:0] KIND_PIXEL     = 3'd4;

	// Operations carried from front to back
	typedef enum logic [2:0] {
		OP_PAL_WRITE,
		OP_PAL_SIZE,
		OP_TRANSP,
		OP_ERROR,
		OP_PIXEL
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  idx;      // palette slot, pixel index or transparent index
		logic [23:0] rgb;      // palette entry color
		logic [8:0]  count;    // saturated palette size
		logic        tv;       // transparency enable
		logic [19:0] flipped;  // flipped screen row, low 20 bits
		logic [10:0] column;   // screen column
		logic        last;     // final pixel of the subimage
	} q_entry_t;

	// Interlace pass row offsets
	function automatic logic [3:0] pass_offset(input logic [1:0] p);
		logic [3:0] r;
		unique case (p)
			2'd0: r = 4'd0;
			2'd1: r = 4'd4;
			2'd2: r = 4'd2;
			2'd3: r = 4'd1;
		endcase
		return r;
	endfunction

	// Interlace pass row steps
	function automatic logic [3:0] pass_step(input logic [1:0] p);
		logic [3:0] r;
		unique case (p)
			2'd0: r = 4'd8;
			2'd1: r = 4'd8;
			2'd2: r = 4'd4;
			2'd3: r = 4'd2;
		endcase
		return r;
	endfunction

endpackage

/* sv/gif_indexed_row_expander.sv */
// Top level of the indexed row expander: front decode, queue, back lookup.
// Depends on grx_pkg, grx_front, grx_queue and grx_back.
//
//   Channel   Direction   Handshake             Payload
//   in        sink        in_valid/in_ready     kind, color_index, palette, descriptor
//   cfg       sink        cfg_valid/cfg_ready   cfg_index, cfg_data
//   out       source      out_valid/out_ready   pix_addr, RGBA, image_error, last_pixel
//
// One item is accepted per cycle while the queue is not full; a pixel beat passes
// its queue write, then palette read and multiply, then the result register.
// Each result uses the single palette read port and the 11x20 address multiplier.
// Reset clears the queue, pipeline valids, walker state and palette size; the palette
// store is not cleared; the user must read it only once written (block does not enforce).
// in_ready drops only when the four-entry queue is full; a stalled out channel
// holds its result while one more result in the lookup stage and four queued beats wait.
`timescale 1ns / 1ps

module gif_indexed_row_expander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  color_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [8:0]  map_size,
	input  logic        transp_valid,
	input  logic [9:0]  img_left,
	input  logic [9:0]  img_top,
	input  logic [10:0] img_width,
	input  logic [10:0] img_height,
	input  logic        interlaced,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] pix_addr,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  alpha,
	output logic        image_error,
	output logic        last_pixel
);

	grx_pkg::q_entry_t q_data;
	grx_pkg::q_entry_t q_head;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic [10:0]       screen_width;

	// Decode beats and walk the subimage
	grx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.color_index  (color_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.map_size     (map_size),
		.transp_valid (transp_valid),
		.img_left     (img_left),
		.img_top      (img_top),
		.img_width    (img_width),
		.img_height   (img_height),
		.interlaced   (interlaced),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_data),
		.screen_width (screen_width)
	);

	// Buffer decoded operations
	grx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Look up colors and form framebuffer writes
	grx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (q_head),
		.q_pop        (q_pop),
		.screen_width (screen_width),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pix_addr     (pix_addr),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.alpha        (alpha),
		.image_error  (image_error),
		.last_pixel   (last_pixel)
	);

endmodule

/* sv/grx_queue.sv */
// Short FIFO of decoded operations between the front and back parts.
// Depends on grx_pkg for the entry type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  grx_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output grx_pkg::q_entry_t head
);

	grx_pkg::q_entry_t                 store_q [grx_pkg::QUEUE_DEPTH];
	logic [grx_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [grx_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [grx_pkg::QCNT_W-1:0]        count_q;

	assign full  = (count_q == grx_pkg::QCNT_W'(grx_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	// Write entry on push
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_SAME(a_no_pop_empty, pop, !empty, "queue popped while empty")
	`ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not follow a push")

endmodule

/* sv/grx_front.sv */
// Front part: configuration registers, item decode and the subimage walker.
// Depends on grx_pkg; feeds decoded operations into grx_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grx_front (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [7:0]        color_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [8:0]        map_size,
	input  logic              transp_valid,
	input  logic [9:0]        img_left,
	input  logic [9:0]        img_top,
	input  logic [10:0]       img_width,
	input  logic [10:0]       img_height,
	input  logic              interlaced,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [10:0]       cfg_data,
	// queue side
	input  logic              q_full,
	output logic              q_push,
	output grx_pkg::q_entry_t q_data,
	output logic [10:0]       screen_width
);

	logic [10:0] scr_w_q;
	logic [10:0] scr_h_q;
	logic [9:0]  sub_left_q;
	logic [9:0]  sub_top_q;
	logic [10:0] sub_width_q;
	logic [10:0] sub_height_q;
	logic [9:0]  column_q;
	logic [10:0] row_pos_q;
	logic [1:0]  pass_q;
	logic        active_q;
	logic        interlace_q;

	logic        accept;
	logic        desc_bad;
	logic [11:0] right_end;
	logic [11:0] bottom_end;
	logic [10:0] col_inc;
	logic        row_end;
	logic [10:0] row_lin;
	logic [10:0] row_il;
	logic        found;
	logic [1:0]  pass_pick;
	logic        done;
	logic [9:0]  column_n;
	logic [10:0] row_n;
	logic [1:0]  pass_n;
	logic [19:0] flipped;

	assign in_ready     = !q_full;
	assign accept       = in_valid && in_ready;
	assign cfg_ready    = 1'b1;
	assign screen_width = scr_w_q;

	// Check descriptor against the screen
	assign right_end  = {2'b00, img_left} + {1'b0, img_width};
	assign bottom_end = {2'b00, img_top} + {1'b0, img_height};
	assign desc_bad   = (right_end > {1'b0, scr_w_q}) || (bottom_end > {1'b0, scr_h_q});

	// Flip the current row onto the screen
	assign flipped = {9'd0, scr_h_q} - ({10'd0, sub_top_q} + {9'd0, row_pos_q} + 20'd1);

	// Walk to the next pixel position
	always_comb begin
		col_inc   = {1'b0, column_q} + 11'd1;
		row_end   = (col_inc >= sub_width_q);
		row_lin   = row_pos_q + 11'd1;
		row_il    = row_pos_q + {7'd0, grx_pkg::pass_step(pass_q)};
		found     = 1'b0;
		pass_pick = 2'd0;
		// first later pass whose start row lies inside the subimage
		priority if (pass_q < 2'd1 && {7'd0, grx_pkg::pass_offset(2'd1)} < sub_height_q) begin
			found     = 1'b1;
			pass_pick = 2'd1;
		end else if (pass_q < 2'd2 &&
				{7'd0, grx_pkg::pass_offset(2'd2)} < sub_height_q) begin
			found     = 1'b1;
			pass_pick = 2'd2;
		end else if (pass_q < 2'd3 &&
				{7'd0, grx_pkg::pass_offset(2'd3)} < sub_height_q) begin
			found     = 1'b1;
			pass_pick = 2'd3;
		end else begin
			found = 1'b0;
		end

		column_n = row_end ? 10'd0 : col_inc[9:0];
		row_n    = row_pos_q;
		pass_n   = pass_q;
		done     = 1'b0;
		if (row_end) begin
			if (!interlace_q) begin
				row_n = row_lin;
				done  = (row_lin >= sub_height_q);
			end else if (row_il < sub_height_q) begin
				row_n = row_il;
			end else if (found) begin
				pass_n = pass_pick;
				row_n  = {7'd0, grx_pkg::pass_offset(pass_pick)};
			end else begin
				pass_n = 2'd0;
				done   = 1'b1;
			end
		end
	end

	// Build the queue entry for the accepted beat
	always_comb begin
		q_push  = 1'b0;
		q_data  = '0;
		q_data.op = grx_pkg::OP_PIXEL;
		unique case (kind)
			grx_pkg::KIND_PAL_ENTRY: begin
				q_push     = accept;
				q_data.op  = grx_pkg::OP_PAL_WRITE;
				q_data.idx = color_index;
				q_data.rgb = {red, green, blue};
			end
			grx_pkg::KIND_PAL_SIZE: begin
				q_push       = accept;
				q_data.op    = grx_pkg::OP_PAL_SIZE;
				q_data.count = (map_size > grx_pkg::PAL_COUNT_MAX) ?
					grx_pkg::PAL_COUNT_MAX : map_size;
			end
			grx_pkg::KIND_TRANSP: begin
				q_push     = accept;
				q_data.op  = grx_pkg::OP_TRANSP;
				q_data.idx = color_index;
				q_data.tv  = transp_valid;
			end
			grx_pkg::KIND_DESC: begin
				q_push    = accept && desc_bad;
				q_data.op = grx_pkg::OP_ERROR;
			end
			grx_pkg::KIND_PIXEL: begin
				q_push         = accept && active_q;
				q_data.op      = grx_pkg::OP_PIXEL;
				q_data.idx     = color_index;
				q_data.flipped = flipped;
				q_data.column  = {1'b0, sub_left_q} + {1'b0, column_q};
				q_data.last    = done;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Hold configuration, saturate writes to the screen limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= grx_pkg::MAX_WIDTH;
			scr_h_q <= grx_pkg::MAX_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				grx_pkg::REG_SCREEN_WIDTH: begin
					scr_w_q <= (cfg_data > grx_pkg::MAX_WIDTH) ? grx_pkg::MAX_WIDTH : cfg_data;
				end
				grx_pkg::REG_SCREEN_HEIGHT: begin
					scr_h_q <= (cfg_data > grx_pkg::MAX_HEIGHT) ?
						grx_pkg::MAX_HEIGHT : cfg_data;
				end
			endcase
		end
	end

	// Track the subimage and the walker position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_left_q   <= '0;
			sub_top_q    <= '0;
			sub_width_q  <= 11'd1;
			sub_height_q <= 11'd1;
			column_q     <= '0;
			row_pos_q    <= '0;
			pass_q       <= '0;
			active_q     <= 1'b0;
			interlace_q  <= 1'b0;
		end else if (accept) begin
			if (kind == grx_pkg::KIND_DESC) begin
				if (desc_bad) begin
					active_q <= 1'b0;
				end else begin
					sub_left_q   <= img_left;
					sub_top_q    <= img_top;
					sub_width_q  <= img_width;
					sub_height_q <= img_height;
					interlace_q  <= interlaced;
					column_q     <= '0;
					row_pos_q    <= '0;
					pass_q       <= '0;
					active_q     <= (img_width != 11'd0) && (img_height != 11'd0);
				end
			end else if (kind == grx_pkg::KIND_PIXEL && active_q) begin
				column_q  <= column_n;
				row_pos_q <= row_n;
				pass_q    <= pass_n;
				if (done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	`ASSERT_SAME(a_walker_in_range, active_q,
		({1'b0, column_q} < sub_width_q) && (row_pos_q < sub_height_q),
		"walker position outside the subimage")

endmodule

/* sv/grx_back.sv */
// Back part: palette store, color lookup, address multiply and result register.
// Depends on grx_pkg; drains operations from grx_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grx_back (
	input  logic              clk,
	input  logic              arst_n,
	// queue side
	input  logic              q_empty,
	input  grx_pkg::q_entry_t head,
	output logic              q_pop,
	input  logic [10:0]       screen_width,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [19:0]       pix_addr,
	output logic [7:0]        out_red,
	output logic [7:0]        out_green,
	output logic [7:0]        out_blue,
	output logic [7:0]        alpha,
	output logic              image_error,
	output logic              last_pixel
);

	logic [23:0] pal_mem [grx_pkg::PALETTE_DEPTH];

	logic [8:0]  pal_count_q;
	logic        transp_on_q;
	logic [7:0]  transp_idx_q;

	// lookup stage
	logic        valid_s1;
	logic        err_s1;
	logic        gray_s1;
	logic [7:0]  col_s1;
	logic [23:0] pal_s1;
	logic [19:0] prod_s1;
	logic [10:0] column_s1;
	logic [7:0]  alpha_s1;
	logic        last_s1;

	// result register
	logic        out_valid_q;
	logic [19:0] pix_addr_q;
	logic [23:0] rgb_q;
	logic [7:0]  alpha_q;
	logic        err_q;
	logic        last_q;

	logic        out_take;
	logic        s1_go;
	logic [8:0]  limit;
	logic [7:0]  col;
	logic [30:0] prod_full;
	logic        is_pix;

	assign out_take = !out_valid_q || out_ready;
	assign s1_go    = !valid_s1 || out_take;
	assign q_pop    = !q_empty && s1_go;
	assign is_pix   = (head.op == grx_pkg::OP_PIXEL);

	// Map a pixel index beyond the palette in use to index 0
	assign limit     = (pal_count_q != 9'd0) ? pal_count_q : grx_pkg::GRAY_LIMIT;
	assign col       = ({1'b0, head.idx} >= limit) ? 8'd0 : head.idx;
	assign prod_full = {20'd0, screen_width} * {11'd0, head.flipped};

	// Write and read the palette
	always_ff @(posedge clk) begin
		if (q_pop && head.op == grx_pkg::OP_PAL_WRITE) begin
			pal_mem[head.idx] <= head.rgb;
		end
		if (q_pop) begin
			pal_s1 <= pal_mem[col];
		end
	end

	// Apply palette size and transparency in queue order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_count_q  <= '0;
			transp_on_q  <= 1'b0;
			transp_idx_q <= '0;
		end else if (q_pop) begin
			if (head.op == grx_pkg::OP_PAL_SIZE) begin
				pal_count_q <= head.count;
			end
			if (head.op == grx_pkg::OP_TRANSP) begin
				transp_on_q  <= head.tv;
				transp_idx_q <= head.idx;
			end
		end
	end

	// Advance the lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= q_pop && (is_pix || head.op == grx_pkg::OP_ERROR);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			err_s1    <= (head.op == grx_pkg::OP_ERROR);
			gray_s1   <= (pal_count_q == 9'd0);
			col_s1    <= col;
			prod_s1   <= prod_full[19:0];
			column_s1 <= head.column;
			alpha_s1  <= (transp_on_q && col == transp_idx_q) ?
				grx_pkg::ALPHA_CLEAR : grx_pkg::ALPHA_OPAQUE;
			last_s1   <= head.last;
		end
	end

	// Load the result register, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s1) begin
			if (err_s1) begin
				pix_addr_q <= '0;
				rgb_q      <= '0;
				alpha_q    <= '0;
				err_q      <= 1'b1;
				last_q     <= 1'b0;
			end else begin
				pix_addr_q <= prod_s1 + {9'd0, column_s1};
				rgb_q      <= gray_s1 ? {col_s1, col_s1, col_s1} : pal_s1;
				alpha_q    <= alpha_s1;
				err_q      <= 1'b0;
				last_q     <= last_s1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pix_addr    = pix_addr_q;
	assign out_red     = rgb_q[23:16];
	assign out_green   = rgb_q[15:8];
	assign out_blue    = rgb_q[7:0];
	assign alpha       = alpha_q;
	assign image_error = err_q;
	assign last_pixel  = last_q;

	`ASSERT_SAME(a_error_clean, out_valid_q && err_q,
		pix_addr_q == 20'd0 && alpha_q == 8'd0 && !last_q,
		"error result carries pixel data")

endmodule

/* tb/gif_indexed_row_expander_tb.sv */
// Self-checking testbench for gif_indexed_row_expander: in-line predictor, random stimulus.
// Depends on grx_pkg and the gif_indexed_row_expander RTL.
`timescale 1ns / 1ps

module gif_indexed_row_expander_tb;

	// Highest item kind; kinds above a pixel are ignored by the block
	localparam logic [2:0] KIND_LAST = 3'd7;

	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;

	// Interlace passes: first row and row step of each pass
	localparam int PASS_START [4] = '{0, 4, 2, 1};
	localparam int PASS_STEP  [4] = '{8, 8, 4, 2};

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  color_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [8:0]  map_size;
		logic        transp_valid;
		logic [9:0]  img_left;
		logic [9:0]  img_top;
		logic [10:0] img_width;
		logic [10:0] img_height;
		logic        interlaced;
	} gif_item_t;

	typedef struct packed {
		logic [19:0] addr;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic        err;
		logic        last;
	} fb_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [7:0]  color_index = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic [8:0]  map_size = '0;
	logic        transp_valid = 1'b0;
	logic [9:0]  img_left = '0;
	logic [9:0]  img_top = '0;
	logic [10:0] img_width = '0;
	logic [10:0] img_height = '0;
	logic        interlaced = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [19:0] pix_addr;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  alpha;
	logic        image_error;
	logic        last_pixel;

	gif_indexed_row_expander dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state, advanced at each accepted beat
	logic [10:0] scr_w = grx_pkg::MAX_WIDTH;
	logic [10:0] scr_h = grx_pkg::MAX_HEIGHT;
	logic [23:0] pal_rgb [grx_pkg::PALETTE_DEPTH];
	logic [8:0]  pal_cnt = '0;
	logic        tr_on = 1'b0;
	logic [7:0]  tr_idx = '0;
	logic [9:0]  sub_left = '0;
	logic [9:0]  sub_top = '0;
	logic [10:0] sub_w = 11'd1;
	logic [10:0] sub_h = 11'd1;
	int          col_cnt = 0;
	int          row_pos = 0;
	int          pass_num = 0;
	logic        walking = 1'b0;
	logic        ilace = 1'b0;

	fb_write_t   fb_writes_due [$];
	int          mismatches = 0;

	// Stimulus planning state, advanced as items are queued
	gif_item_t   stream_q [$];
	gif_item_t   held;
	int          items_sent = 0;
	int          items_taken = 0;
	bit [255:0]  slot_loaded = '0;
	int          plan_cnt = 0;
	int          plan_tr = 0;

	bit          idling = 1'b1;
	int          hold_asks = 0;
	int          hold_done = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          gap_left = 0;
	int          quiet = 0;

	// Apply one accepted beat to the predictor and queue any framebuffer write it makes
	function automatic void expand_item(input gif_item_t it);
		fb_write_t   w;
		int          limit;
		int          col;
		logic [23:0] rgb;
		bit [31:0]   flipped;
		bit [31:0]   addr;
		logic        done;
		w = '0;
		done = 1'b0;
		case (it.kind)
			grx_pkg::KIND_PAL_ENTRY: pal_rgb[it.color_index] = {it.red, it.green, it.blue};
			grx_pkg::KIND_PAL_SIZE: pal_cnt = (it.map_size > grx_pkg::PAL_COUNT_MAX) ?
				grx_pkg::PAL_COUNT_MAX : it.map_size;
			grx_pkg::KIND_TRANSP: begin
				tr_on = it.transp_valid;
				tr_idx = it.color_index;
			end
			grx_pkg::KIND_DESC: begin
				if (int'(it.img_left) + int'(it.img_width) > int'(scr_w) ||
				    int'(it.img_top) + int'(it.img_height) > int'(scr_h)) begin
					walking = 1'b0;
					w.err = 1'b1;
					fb_writes_due.push_back(w);
				end else begin
					sub_left = it.img_left;
					sub_top = it.img_top;
					sub_w = it.img_width;
					sub_h = it.img_height;
					ilace = it.interlaced;
					col_cnt = 0;
					row_pos = 0;
					pass_num = 0;
					walking = (it.img_width != 0 && it.img_height != 0);
				end
			end
			grx_pkg::KIND_PIXEL: if (walking) begin
				limit = (pal_cnt != 0) ? int'(pal_cnt) : int'(grx_pkg::GRAY_LIMIT);
				col = (int'(it.color_index) >= limit) ? 0 : int'(it.color_index);
				rgb = (pal_cnt != 0) ? pal_rgb[col] : {3{8'(col)}};
				flipped = 32'(scr_h) - (32'(sub_top) + 32'(row_pos) + 32'd1);
				addr = 32'(scr_w) * flipped + 32'(sub_left) + 32'(col_cnt);
				w.addr = addr[19:0];
				w.r = rgb[23:16];
				w.g = rgb[15:8];
				w.b = rgb[7:0];
				w.a = (tr_on && col == int'(tr_idx)) ? grx_pkg::ALPHA_CLEAR :
					grx_pkg::ALPHA_OPAQUE;
				// advance column, then row, then interlace pass
				col_cnt++;
				if (col_cnt >= int'(sub_w)) begin
					col_cnt = 0;
					if (!ilace) begin
						row_pos++;
						done = (row_pos >= int'(sub_h));
					end else begin
						row_pos += PASS_STEP[pass_num];
						while (!done && row_pos >= int'(sub_h)) begin
							pass_num++;
							if (pass_num == 4) begin
								pass_num = 0;
								done = 1'b1;
							end else begin
								row_pos = PASS_START[pass_num];
							end
						end
					end
				end
				w.last = done;
				if (done)
					walking = 1'b0;
				fb_writes_due.push_back(w);
			end
			default: ;
		endcase
	endfunction

	// Item with every field but the kind random; the caller overrides what the kind uses
	function automatic gif_item_t blank_item(input logic [2:0] k);
		gif_item_t it;
		it.kind = k;
		it.color_index = 8'($urandom);
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		it.map_size = 9'($urandom);
		it.transp_valid = 1'($urandom);
		it.img_left = 10'($urandom);
		it.img_top = 10'($urandom);
		it.img_width = 11'($urandom);
		it.img_height = 11'($urandom);
		it.interlaced = 1'($urandom);
		return it;
	endfunction

	function automatic void send(input gif_item_t it);
		stream_q.push_back(it);
		items_sent++;
	endfunction

	function automatic void put_entry(input int slot, input int r, input int g, input int b);
		gif_item_t it;
		it = blank_item(grx_pkg::KIND_PAL_ENTRY);
		it.color_index = 8'(slot);
		it.red = 8'(r);
		it.green = 8'(g);
		it.blue = 8'(b);
		slot_loaded[slot] = 1'b1;
		send(it);
	endfunction

	function automatic void put_size(input int m);
		gif_item_t it;
		it = blank_item(grx_pkg::KIND_PAL_SIZE);
		it.map_size = 9'(m);
		plan_cnt = (m > grx_pkg::PALETTE_DEPTH) ? grx_pkg::PALETTE_DEPTH : m;
		send(it);
	endfunction

	function automatic void put_transp(input int on, input int idx);
		gif_item_t it;
		it = blank_item(grx_pkg::KIND_TRANSP);
		it.transp_valid = 1'(on);
		it.color_index = 8'(idx);
		plan_tr = idx;
		send(it);
	endfunction

	function automatic void put_desc(input int l, input int t, input int w, input int h,
	                                 input int il);
		gif_item_t it;
		it = blank_item(grx_pkg::KIND_DESC);
		it.img_left = 10'(l);
		it.img_top = 10'(t);
		it.img_width = 11'(w);
		it.img_height = 11'(h);
		it.interlaced = 1'(il);
		send(it);
	endfunction

	// Load the palette slot a pixel will read before the pixel itself
	function automatic void put_pixel(input int cidx);
		gif_item_t it;
		int        col;
		if (plan_cnt != 0) begin
			col = (cidx >= plan_cnt) ? 0 : cidx;
			if (!slot_loaded[col])
				put_entry(col, $urandom_range(0, 255), $urandom_range(0, 255),
				          $urandom_range(0, 255));
		end
		it = blank_item(grx_pkg::KIND_PIXEL);
		it.color_index = 8'(cidx);
		send(it);
	endfunction

	function automatic int pick_index();
		int lim;
		lim = (plan_cnt != 0) ? plan_cnt : int'(grx_pkg::GRAY_LIMIT);
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, lim - 1);
			2: return $urandom_range(0, 255);
			default: return plan_tr;
		endcase
	endfunction

	// One well-formed subimage, sometimes cut short or overrun
	function automatic void random_image();
		int l, t, w, h, n;
		l = $urandom_range(0, int'(scr_w) - 1);
		t = $urandom_range(0, int'(scr_h) - 1);
		w = $urandom_range(1, (int'(scr_w) - l < 8) ? int'(scr_w) - l : 8);
		h = $urandom_range(1, (int'(scr_h) - t < 12) ? int'(scr_h) - t : 12);
		put_desc(l, t, w, h, $urandom_range(0, 1));
		n = w * h;
		case ($urandom_range(0, 9))
			0: n = $urandom_range(0, n - 1);
			1: n += $urandom_range(1, 3);
			default: ;
		endcase
		repeat (n) begin
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1))
					put_entry($urandom_range(0, 255), $urandom_range(0, 255),
					          $urandom_range(0, 255), $urandom_range(0, 255));
				else
					put_transp($urandom_range(0, 1), pick_index());
			end
			put_pixel(pick_index());
		end
	endfunction

	// Noise between subimages
	function automatic void random_side();
		case ($urandom_range(0, 5))
			0: repeat ($urandom_range(1, 4))
				put_entry($urandom_range(0, 255), $urandom_range(0, 255),
				          $urandom_range(0, 255), $urandom_range(0, 255));
			1: case ($urandom_range(0, 5))
				0: put_size(0);
				1: put_size($urandom_range(grx_pkg::PALETTE_DEPTH + 1, 511));
				2: put_size($urandom_range(1, grx_pkg::PALETTE_DEPTH));
				default: put_size($urandom_range(1, 16));
			endcase
			2: put_transp($urandom_range(0, 1), pick_index());
			3: if ($urandom_range(0, 1))
				put_desc($urandom_range(0, 1023), $urandom_range(0, 1023),
				         $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 1));
			else if ($urandom_range(0, 1))
				put_desc($urandom_range(0, 1023), $urandom_range(0, 1023), 0,
				         $urandom_range(0, 2047), $urandom_range(0, 1));
			else
				put_desc($urandom_range(0, 1023), $urandom_range(0, 1023),
				         $urandom_range(0, 2047), 0, $urandom_range(0, 1));
			4: send(blank_item(3'($urandom_range(int'(grx_pkg::KIND_PIXEL) + 1,
			                                     int'(KIND_LAST)))));
			default: put_pixel(pick_index());
		endcase
	endfunction

	function automatic void random_run(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 60)
				random_image();
			else
				random_side();
		end
	endfunction

	// Write one screen register; only called while the block is idle
	task automatic write_reg(input logic idx, input logic [10:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == grx_pkg::REG_SCREEN_WIDTH)
			scr_w = (data > grx_pkg::MAX_WIDTH) ? grx_pkg::MAX_WIDTH : data;
		else
			scr_h = (data > grx_pkg::MAX_HEIGHT) ? grx_pkg::MAX_HEIGHT : data;
	endtask

	// Wait for every queued beat and every expected write, then let the pipe drain
	task automatic settle();
		while (items_taken != items_sent || fb_writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Input driver: hold each beat until accepted, add random gaps between beats while idling
	always @(posedge clk) begin : drv
		gif_item_t it;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expand_item(held);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (idling && gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					it = stream_q.pop_front();
					held = it;
					kind <= it.kind;
					color_index <= it.color_index;
					red <= it.red;
					green <= it.green;
					blue <= it.blue;
					map_size <= it.map_size;
					transp_valid <= it.transp_valid;
					img_left <= it.img_left;
					img_top <= it.img_top;
					img_width <= it.img_width;
					img_height <= it.img_height;
					interlaced <= it.interlaced;
					in_valid <= 1'b1;
					if (idling && $urandom_range(0, 9) == 0)
						gap_left = $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each accepted beat, drive out_ready with stalls
	always @(posedge clk) begin : mon
		fb_write_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (fb_writes_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got pix_addr 0x%0h err %0b",
					         $time, pix_addr, image_error);
					mismatches++;
				end else begin
					want = fb_writes_due.pop_front();
					cmp_field("pix_addr", 32'(want.addr), 32'(pix_addr));
					cmp_field("out_red", 32'(want.r), 32'(out_red));
					cmp_field("out_green", 32'(want.g), 32'(out_green));
					cmp_field("out_blue", 32'(want.b), 32'(out_blue));
					cmp_field("alpha", 32'(want.a), 32'(alpha));
					cmp_field("image_error", 32'(want.err), 32'(image_error));
					cmp_field("last_pixel", 32'(want.last), 32'(last_pixel));
				end
			end
			if (hold_done != hold_asks) begin
				hold_done = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (idling && stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Full screen, directed corners and special cases
		write_reg(grx_pkg::REG_SCREEN_WIDTH, 11'd1024);
		write_reg(grx_pkg::REG_SCREEN_HEIGHT, 11'd1024);
		put_pixel(7);
		for (int k = int'(grx_pkg::KIND_PIXEL) + 1; k <= int'(KIND_LAST); k++)
			send(blank_item(3'(k)));
		put_desc(1023, 0, 2, 1, 0);
		put_desc(0, 1000, 1, 25, 0);
		put_desc(4, 4, 0, 5, 0);
		put_pixel(9);
		put_desc(4, 4, 5, 0, 1);
		put_desc(1023, 1023, 1, 1, 1);
		put_pixel(255);
		put_entry(0, 8'hff, 8'h00, 8'hff);
		put_entry(255, 8'h00, 8'hff, 8'h00);
		put_size(511);
		put_transp(1, 255);
		put_desc(0, 0, 1024, 1024, 0);
		put_pixel(255);
		put_pixel(0);
		put_transp(0, 255);
		put_pixel(255);
		put_size(0);
		put_pixel(254);
		put_size(1);
		put_pixel(200);
		// leave an interlaced subimage open across the screen change
		put_desc(3, 5, 2, 10, 1);
		put_pixel(0);
		put_pixel(0);
		put_pixel(1);
		settle();

		// Saturated width, short screen: finish the open subimage with wrapped rows
		write_reg(grx_pkg::REG_SCREEN_WIDTH, 11'd2047);
		write_reg(grx_pkg::REG_SCREEN_HEIGHT, 11'd7);
		repeat (17) put_pixel(pick_index());
		random_run(240);
		settle();

		// Smallest screen
		write_reg(grx_pkg::REG_SCREEN_WIDTH, 11'd1);
		write_reg(grx_pkg::REG_SCREEN_HEIGHT, 11'd1);
		random_run(180);
		settle();

		// Odd screen size, with a long hold-off on the result side
		write_reg(grx_pkg::REG_SCREEN_WIDTH, 11'd37);
		write_reg(grx_pkg::REG_SCREEN_HEIGHT, 11'd29);
		hold_asks++;
		random_run(340);
		settle();

		// Last part at full rate on both sides
		idling = 1'b0;
		write_reg(grx_pkg::REG_SCREEN_WIDTH, 11'd1000);
		write_reg(grx_pkg::REG_SCREEN_HEIGHT, 11'd1023);
		random_run(330);
		settle();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/grx_pkg.sv
sv/grx_queue.sv
sv/grx_front.sv
sv/grx_back.sv
sv/gif_indexed_row_expander.sv
tb/gif_indexed_row_expander_tb.sv
